[sv/fcd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fcd_pkg
// Shared types, character codes and command text for the framed command
// decoder.
// ----------------------------------------------------------------------------
package fcd_pkg;

    // widths of the result fields and of the frame byte count
    localparam int FRAME_CNT_W = 6;
    localparam int DUTY_W      = 7;
    localparam int KIND_W      = 2;

    // framing characters
    localparam logic [7:0] CH_START = 8'h23;  // '#'
    localparam logic [7:0] CH_END   = 8'h24;  // '$'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

    // command kinds reported when a frame closes
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_AUTO   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MANUAL = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DUTY   = 2'd3;

    // candidate commands still alive in the open frame
    typedef struct packed {
        logic pwm;
        logic manual;
        logic auto_cmd;
    } t_match_flags;

    // one decoded result
    typedef struct packed {
        logic              auto_mode;
        logic [DUTY_W-1:0] duty_value;
        logic              frame_end;
        logic              frame_truncated;
        logic [KIND_W-1:0] command_kind;
    } t_fcd_result;

    // expected byte of "#auto$" at a frame position below six
    function automatic logic [7:0] auto_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h23;  // '#'
            3'd1:    c = 8'h61;  // 'a'
            3'd2:    c = 8'h75;  // 'u'
            3'd3:    c = 8'h74;  // 't'
            3'd4:    c = 8'h6f;  // 'o'
            default: c = 8'h24;  // '$'
        endcase
        return c;
    endfunction

    // expected byte of "#manual$"
    function automatic logic [7:0] manual_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h23;  // '#'
            3'd1:    c = 8'h6d;  // 'm'
            3'd2:    c = 8'h61;  // 'a'
            3'd3:    c = 8'h6e;  // 'n'
            3'd4:    c = 8'h75;  // 'u'
            3'd5:    c = 8'h61;  // 'a'
            3'd6:    c = 8'h6c;  // 'l'
            default: c = 8'h24;  // '$'
        endcase
        return c;
    endfunction

    // expected byte of the "#PWM" prefix
    function automatic logic [7:0] pwm_char(input logic [1:0] pos);
        logic [7:0] c;
        unique case (pos)
            2'd0:    c = 8'h23;  // '#'
            2'd1:    c = 8'h50;  // 'P'
            2'd2:    c = 8'h57;  // 'W'
            default: c = 8'h4d;  // 'M'
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

[sv/fcd_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fcd_in_if
// Byte channel into the decoder: valid, ready and one received byte.
// ----------------------------------------------------------------------------
interface fcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

[sv/fcd_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fcd_out_if
// Result channel out of the decoder: valid, ready and the decoded status.
// ----------------------------------------------------------------------------
interface fcd_out_if
    import fcd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              auto_mode;
    logic [DUTY_W-1:0] duty_value;
    logic              frame_end;
    logic              frame_truncated;
    logic [KIND_W-1:0] command_kind;

    modport source (output valid, output auto_mode, output duty_value, output frame_end,
                    output frame_truncated, output command_kind, input ready);
    modport sink   (input valid, input auto_mode, input duty_value, input frame_end,
                    input frame_truncated, input command_kind, output ready);
endinterface
`default_nettype wire

[sv/fcd_decode.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fcd_decode
// Frame state and on-the-fly matcher: consumes one byte per advance, updates
// the frame, mode and duty registers and forms the result for that byte.
// ----------------------------------------------------------------------------
module fcd_decode
    import fcd_pkg::*;
#(
    parameter int MAX_FRAME = 35
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_adv,
    input  wire logic [7:0]  i_byte,
    output t_fcd_result      o_result
);

    localparam logic [FRAME_CNT_W-1:0] MaxFrameCnt = FRAME_CNT_W'(MAX_FRAME);

    // digit parser phases
    localparam logic [1:0] PH_FIRST = 2'd0;
    localparam logic [1:0] PH_ONE   = 2'd1;
    localparam logic [1:0] PH_DONE  = 2'd2;

    logic                   r_capturing, n_capturing;
    logic [FRAME_CNT_W-1:0] r_frame_count, n_frame_count;
    t_match_flags           r_flags, n_flags;
    logic [DUTY_W-1:0]      r_digit_acc, n_digit_acc;
    logic [1:0]             r_digit_phase, n_digit_phase;
    logic                   r_mode_auto, n_mode_auto;
    logic [DUTY_W-1:0]      r_duty, n_duty;

    logic                   close_frame;
    logic                   is_digit;
    logic [DUTY_W-1:0]      digit_val;

    assign is_digit  = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign digit_val = DUTY_W'(i_byte[3:0]);

    // next state and result for the current byte
    always_comb begin
        n_capturing   = r_capturing;
        n_frame_count = r_frame_count;
        n_flags       = r_flags;
        n_digit_acc   = r_digit_acc;
        n_digit_phase = r_digit_phase;
        n_mode_auto   = r_mode_auto;
        n_duty        = r_duty;
        close_frame   = 1'b0;

        o_result.frame_end       = 1'b0;
        o_result.frame_truncated = 1'b0;
        o_result.command_kind    = KIND_NONE;

        if (i_byte == CH_START) begin
            // start or restart a frame
            n_capturing   = 1'b1;
            n_frame_count = FRAME_CNT_W'(1);
            n_flags       = '{pwm: 1'b1, manual: 1'b1, auto_cmd: 1'b1};
            n_digit_acc   = '0;
            n_digit_phase = PH_FIRST;
        end else if (r_capturing) begin
            if (r_frame_count >= MaxFrameCnt) begin
                // frame full: drop this byte and close
                close_frame              = 1'b1;
                o_result.frame_truncated = 1'b1;
            end else begin
                // match against the command texts
                if (r_frame_count >= FRAME_CNT_W'(6) ||
                    i_byte != auto_char(r_frame_count[2:0])) begin
                    n_flags.auto_cmd = 1'b0;
                end
                if (r_frame_count >= FRAME_CNT_W'(8) ||
                    i_byte != manual_char(r_frame_count[2:0])) begin
                    n_flags.manual = 1'b0;
                end
                if (r_frame_count < FRAME_CNT_W'(4)) begin
                    if (i_byte != pwm_char(r_frame_count[1:0])) begin
                        n_flags.pwm = 1'b0;
                    end
                end else if (r_frame_count < FRAME_CNT_W'(6)) begin
                    // up to two duty digits after the prefix
                    if (r_digit_phase == PH_FIRST) begin
                        if (is_digit) begin
                            n_digit_acc   = digit_val;
                            n_digit_phase = PH_ONE;
                        end else begin
                            n_digit_phase = PH_DONE;
                        end
                    end else if (r_digit_phase == PH_ONE) begin
                        if (is_digit) begin
                            n_digit_acc = DUTY_W'(r_digit_acc * DUTY_W'(10) + digit_val);
                        end
                        n_digit_phase = PH_DONE;
                    end
                end
                n_frame_count = r_frame_count + FRAME_CNT_W'(1);
                close_frame   = (i_byte == CH_END);
            end
        end

        if (close_frame) begin
            // judge the closed frame, then clear it
            o_result.frame_end = 1'b1;
            priority if (n_flags.auto_cmd) begin
                n_mode_auto           = 1'b1;
                o_result.command_kind = KIND_AUTO;
            end else if (n_flags.manual) begin
                n_mode_auto           = 1'b0;
                o_result.command_kind = KIND_MANUAL;
            end else if (!r_mode_auto && n_flags.pwm && n_frame_count >= FRAME_CNT_W'(4)) begin
                n_duty                = n_digit_acc;
                o_result.command_kind = KIND_DUTY;
            end else begin
                o_result.command_kind = KIND_NONE;
            end
            n_capturing   = 1'b0;
            n_frame_count = '0;
            n_flags       = '0;
            n_digit_acc   = '0;
            n_digit_phase = PH_FIRST;
        end

        o_result.auto_mode  = n_mode_auto;
        o_result.duty_value = n_duty;
    end

    // state registers, updated once per consumed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capturing   <= 1'b0;
            r_frame_count <= '0;
            r_flags       <= '0;
            r_digit_acc   <= '0;
            r_digit_phase <= PH_FIRST;
            r_mode_auto   <= 1'b0;
            r_duty        <= '0;
        end else if (i_adv) begin
            r_capturing   <= n_capturing;
            r_frame_count <= n_frame_count;
            r_flags       <= n_flags;
            r_digit_acc   <= n_digit_acc;
            r_digit_phase <= n_digit_phase;
            r_mode_auto   <= n_mode_auto;
            r_duty        <= n_duty;
        end
    end

endmodule
`default_nettype wire

[sv/framed_command_decoder_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// framed_command_decoder_core
// Decodes '#'..'$' framed text commands (auto, manual, PWM duty) from a byte
// stream, one result per received byte.
// ----------------------------------------------------------------------------
// Usage:
//   i_rx  : byte channel, one rx_byte per transfer (valid/ready).
//   o_res : result channel, one transfer per input byte carrying the mode,
//           the duty value, frame_end, frame_truncated and command_kind.
//   A result is offered once its byte has moved from the input register
//   into the result register; a stall on o_res can hold it first.
//   Throughput: one byte per cycle while o_res.ready is high; the whole
//   per-byte decode is a single pass of compare and small add logic
//   between the two registers.
//   Reset (i_rst_n low, synchronous): no frame open, manual mode, duty 0,
//   both channel stages empty.
//   Stall: while o_res.ready is low the result register holds; the input
//   register still takes one more byte, after which i_rx.ready drops until
//   the result is taken.
//   MAX_FRAME (8..63) sets the byte count at which an open frame is closed.
// ----------------------------------------------------------------------------
module framed_command_decoder_core
    import fcd_pkg::*;
#(
    parameter int MAX_FRAME = 35
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fcd_in_if.sink     i_rx,
    fcd_out_if.source  o_res
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    t_fcd_result r_out;
    t_fcd_result dec_result;
    logic        adv;

    // the input stage moves forward when the result register can take it
    assign adv        = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // frame state and matching
    fcd_decode #(
        .MAX_FRAME (MAX_FRAME)
    ) u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_byte   (r_in_byte),
        .o_result (dec_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= dec_result;
        end
    end

    // result channel
    assign o_res.valid           = r_out_valid;
    assign o_res.auto_mode       = r_out.auto_mode;
    assign o_res.duty_value      = r_out.duty_value;
    assign o_res.frame_end       = r_out.frame_end;
    assign o_res.frame_truncated = r_out.frame_truncated;
    assign o_res.command_kind    = r_out.command_kind;

endmodule
`default_nettype wire

[tb/tb_framed_command_decoder_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_framed_command_decoder_core
// Streams framed command text into the decoder and checks every status
// transfer against a cycle-free decode of the same bytes. A short table of
// commands comes first, then random frames: mode commands, PWM duty commands,
// frames cut by the length limit, damaged and restarted frames, and line
// noise. Sender gaps, receiver stalls and one long receiver hold-off are
// spread over the run.
// ----------------------------------------------------------------------------
module tb_framed_command_decoder_core
    import fcd_pkg::*;
;

    localparam int MAX_FRAME    = 35;
    localparam int FRAMED_ITEMS = 1800;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;

    // command text, first character in the top byte
    localparam logic [47:0] AUTO_TEXT   = "#auto$";
    localparam logic [63:0] MANUAL_TEXT = "#manual$";
    localparam logic [31:0] PWM_TEXT    = "#PWM";

    // characters used to spoil the duty digits
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_LET_A = "A";

    // handshake pacing over the run
    typedef enum int {
        PH_FREE,
        PH_TX_IDLE,
        PH_RX_STALL,
        PH_BOTH,
        PH_PRESSURE
    } t_phase;

    logic i_clk;
    logic i_rst_n;
    bit   run_on;

    fcd_in_if  rx_if ();
    fcd_out_if res_if ();

    framed_command_decoder_core #(
        .MAX_FRAME(MAX_FRAME)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rx   (rx_if),
        .o_res  (res_if)
    );

    // stimulus table: byte, whether the status is typed in, typed status
    logic [7:0]  stim_byte[$];
    bit          stim_fixed[$];
    t_fcd_result stim_want[$];
    int          n_directed;

    t_fcd_result pending_status_q[$];
    int          accepted_cnt;
    int          got_cnt;
    int          err_count;

    // decoder state mirror
    bit                     dec_capturing;
    logic [FRAME_CNT_W-1:0] dec_count;
    t_match_flags           dec_flags;
    logic [DUTY_W-1:0]      dec_acc;
    logic [1:0]             dec_phase;
    logic                   dec_auto;
    logic [DUTY_W-1:0]      dec_duty;

    // ------------------------------------------------------------------
    // decode mirror
    // ------------------------------------------------------------------
    function automatic void close_frame();
        dec_capturing = 1'b0;
        dec_count     = '0;
        dec_flags     = '0;
        dec_acc       = '0;
        dec_phase     = 2'd0;
    endfunction

    // mode or duty update when a frame closes
    function automatic logic [KIND_W-1:0] judge_frame();
        logic [KIND_W-1:0] kind;
        kind = KIND_NONE;
        if (dec_flags.auto_cmd) begin
            dec_auto = 1'b1;
            kind     = KIND_AUTO;
        end else if (dec_flags.manual) begin
            dec_auto = 1'b0;
            kind     = KIND_MANUAL;
        end else if (!dec_auto && dec_flags.pwm && dec_count >= 4) begin
            dec_duty = dec_acc;
            kind     = KIND_DUTY;
        end
        return kind;
    endfunction

    // one received byte in, the status it leaves behind out
    function automatic t_fcd_result decode_byte(input logic [7:0] b);
        t_fcd_result r;
        int          k;
        bit          is_digit;
        r = '0;
        if (b == CH_START) begin
            // a hash always opens a fresh frame, even past the limit
            dec_capturing = 1'b1;
            dec_count     = FRAME_CNT_W'(1);
            dec_flags     = '1;
            dec_acc       = '0;
            dec_phase     = 2'd0;
        end else if (dec_capturing) begin
            if (dec_count >= MAX_FRAME) begin
                // frame full: close it as it stands and drop this byte
                r.frame_end       = 1'b1;
                r.frame_truncated = 1'b1;
                r.command_kind    = judge_frame();
                close_frame();
            end else begin
                k        = dec_count;
                is_digit = (b >= CH_ZERO && b <= CH_NINE);
                if (k >= 6) begin
                    dec_flags.auto_cmd = 1'b0;
                end else if (b != AUTO_TEXT[8*(5-k) +: 8]) begin
                    dec_flags.auto_cmd = 1'b0;
                end
                if (k >= 8) begin
                    dec_flags.manual = 1'b0;
                end else if (b != MANUAL_TEXT[8*(7-k) +: 8]) begin
                    dec_flags.manual = 1'b0;
                end
                if (k < 4) begin
                    if (b != PWM_TEXT[8*(3-k) +: 8]) begin
                        dec_flags.pwm = 1'b0;
                    end
                end else if (k < 6) begin
                    // up to two duty digits right after the prefix
                    if (dec_phase == 2'd0) begin
                        if (is_digit) begin
                            dec_acc   = DUTY_W'(b - CH_ZERO);
                            dec_phase = 2'd1;
                        end else begin
                            dec_phase = 2'd2;
                        end
                    end else if (dec_phase == 2'd1) begin
                        if (is_digit) begin
                            dec_acc = DUTY_W'(dec_acc * 10 + (b - CH_ZERO));
                        end
                        dec_phase = 2'd2;
                    end
                end
                dec_count = FRAME_CNT_W'(k + 1);
                if (b == CH_END) begin
                    r.frame_end    = 1'b1;
                    r.command_kind = judge_frame();
                    close_frame();
                end
            end
        end
        r.auto_mode  = dec_auto;
        r.duty_value = dec_duty;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    function automatic t_fcd_result mk_res(input logic a, input logic [DUTY_W-1:0] d,
                                           input logic e, input logic t,
                                           input logic [KIND_W-1:0] k);
        t_fcd_result r;
        r.auto_mode       = a;
        r.duty_value      = d;
        r.frame_end       = e;
        r.frame_truncated = t;
        r.command_kind    = k;
        return r;
    endfunction

    function automatic logic [7:0] rand_filler();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (b == CH_START || b == CH_END) begin
            b = 8'($urandom_range(255));
        end
        return b;
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(CH_ZERO + $urandom_range(9));
    endfunction

    task automatic push_byte(input logic [7:0] b, input bit fixed, input t_fcd_result want);
        stim_byte.push_back(b);
        stim_fixed.push_back(fixed);
        stim_want.push_back(fixed ? want : t_fcd_result'('0));
    endtask

    // text with an optional spoiled character; typed status on the last byte
    task automatic add_text(input string s, input int bad_pos, input bit fixed_last,
                            input t_fcd_result want);
        int         i;
        logic [7:0] b;
        for (i = 0; i < s.len(); i++) begin
            b = (i == bad_pos) ? rand_filler() : 8'(s[i]);
            push_byte(b, fixed_last && (i == s.len() - 1), want);
        end
    endtask

    // "#PWM" with assorted digit fields and tails
    task automatic add_pwm_frame();
        int i;
        int bad;
        bad = ($urandom_range(9) == 0) ? int'($urandom_range(1, 3)) : -1;
        add_text("#PWM", bad, 1'b0, '0);
        case ($urandom_range(5))
            0: ;
            1: push_byte(rand_digit(), 1'b0, '0);
            2: begin
                push_byte(rand_digit(), 1'b0, '0);
                push_byte(rand_digit(), 1'b0, '0);
            end
            3: begin
                // sign or space ahead of the digits
                case ($urandom_range(2))
                    0:       push_byte(CH_PLUS, 1'b0, '0);
                    1:       push_byte(CH_MINUS, 1'b0, '0);
                    default: push_byte(CH_SPACE, 1'b0, '0);
                endcase
                push_byte(rand_digit(), 1'b0, '0);
            end
            4: begin
                push_byte(rand_digit(), 1'b0, '0);
                push_byte(8'(CH_LET_A + $urandom_range(25)), 1'b0, '0);
            end
            default: begin
                for (i = 0; i < 3; i++) push_byte(rand_digit(), 1'b0, '0);
            end
        endcase
        for (i = $urandom_range(2); i > 0; i--) push_byte(rand_filler(), 1'b0, '0);
        push_byte(CH_END, 1'b0, '0);
    endtask

    // frame that runs into the length limit, or closes just at it
    task automatic add_long_frame();
        int i;
        int held;
        bit clean_close;
        push_byte(CH_START, 1'b0, '0);
        held = 1;
        if ($urandom_range(1)) begin
            add_text("PWM", -1, 1'b0, '0);
            push_byte(rand_digit(), 1'b0, '0);
            push_byte(rand_digit(), 1'b0, '0);
            held = 6;
        end
        clean_close = ($urandom_range(3) == 0);
        while (held < (clean_close ? MAX_FRAME - 1 : MAX_FRAME)) begin
            push_byte(rand_filler(), 1'b0, '0);
            held++;
        end
        if (clean_close) begin
            push_byte(CH_END, 1'b0, '0);
        end else begin
            // overflow byte: dropped end mark, dropped filler, or a restart
            case ($urandom_range(2))
                0:       push_byte(CH_END, 1'b0, '0);
                1:       push_byte(rand_filler(), 1'b0, '0);
                default: push_byte(CH_START, 1'b0, '0);
            endcase
        end
        for (i = $urandom_range(2); i > 0; i--) push_byte(rand_filler(), 1'b0, '0);
    endtask

    // mode command with one character replaced, dropped or added
    task automatic add_broken_mode();
        string s;
        int    how;
        int    pos;
        int    i;
        s   = $urandom_range(1) ? "#auto$" : "#manual$";
        how = $urandom_range(2);
        pos = $urandom_range(1, s.len() - 1);
        if (how == 0) begin
            add_text(s, pos, 1'b0, '0);
        end else begin
            for (i = 0; i < s.len(); i++) begin
                if (how == 2 && i == pos) push_byte(rand_filler(), 1'b0, '0);
                if (!(how == 1 && i == pos && i < s.len() - 1)) begin
                    push_byte(8'(s[i]), 1'b0, '0);
                end
            end
        end
    endtask

    // partial command cut short by a new hash
    task automatic add_restart();
        string s;
        int    cut;
        int    i;
        case ($urandom_range(2))
            0:       s = "#auto$";
            1:       s = "#manual$";
            default: s = "#PWM73$";
        endcase
        cut = $urandom_range(1, s.len() - 1);
        for (i = 0; i < cut; i++) push_byte(8'(s[i]), 1'b0, '0);
        case ($urandom_range(2))
            0:       add_text("#auto$", -1, 1'b0, '0);
            1:       add_text("#manual$", -1, 1'b0, '0);
            default: add_pwm_frame();
        endcase
    endtask

    task automatic build_random(input int target);
        int framed;
        int pick;
        int mark;
        int i;
        framed = 0;
        while (framed < target) begin
            pick = $urandom_range(99);
            mark = stim_byte.size();
            if (pick < 12) begin
                add_text("#auto$", -1, 1'b0, '0);
            end else if (pick < 27) begin
                add_text("#manual$", -1, 1'b0, '0);
            end else if (pick < 55) begin
                add_pwm_frame();
            end else if (pick < 65) begin
                add_long_frame();
            end else if (pick < 77) begin
                add_broken_mode();
            end else if (pick < 87) begin
                add_restart();
            end else begin
                // raw line noise, not counted as frame traffic
                for (i = $urandom_range(1, 6); i > 0; i--) begin
                    push_byte(8'($urandom_range(255)), 1'b0, '0);
                end
                mark = stim_byte.size();
            end
            framed += stim_byte.size() - mark;
        end
    endtask

    // pacing phase for a given item position
    function automatic t_phase phase_of(input int idx);
        int span;
        int q;
        span = stim_byte.size() - n_directed;
        if (idx < n_directed || span <= 0) return PH_FREE;
        q = ((idx - n_directed) * 5) / span;
        if (q >= 4) return PH_PRESSURE;
        return t_phase'(q);
    endfunction

    task automatic check_field(input string fname, input int idx, input int want,
                               input int got);
        if (want != got) begin
            err_count++;
            $display("%0t: status %0d %s mismatch, expected %0d, actual %0d",
                     $time, idx, fname, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // transfer monitor and status check
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : status_monitor
        t_fcd_result pred;
        t_fcd_result got;
        t_fcd_result want;
        if (i_rst_n) begin
            // byte transfer: predict, or take the typed status
            if (rx_if.valid && rx_if.ready) begin
                pred = decode_byte(rx_if.rx_byte);
                pending_status_q.push_back(stim_fixed[accepted_cnt] ?
                                           stim_want[accepted_cnt] : pred);
                accepted_cnt++;
            end
            // status transfer
            if (res_if.valid && res_if.ready) begin
                got.auto_mode       = res_if.auto_mode;
                got.duty_value      = res_if.duty_value;
                got.frame_end       = res_if.frame_end;
                got.frame_truncated = res_if.frame_truncated;
                got.command_kind    = res_if.command_kind;
                if (pending_status_q.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected status %0d, expected none, actual %h",
                             $time, got_cnt, got);
                end else begin
                    want = pending_status_q.pop_front();
                    check_field("auto_mode", got_cnt, want.auto_mode, got.auto_mode);
                    check_field("duty_value", got_cnt, want.duty_value, got.duty_value);
                    check_field("frame_end", got_cnt, want.frame_end, got.frame_end);
                    check_field("frame_truncated", got_cnt, want.frame_truncated,
                                got.frame_truncated);
                    check_field("command_kind", got_cnt, want.command_kind,
                                got.command_kind);
                end
                got_cnt++;
            end
        end
    end

    // ------------------------------------------------------------------
    // byte sender
    // ------------------------------------------------------------------
    initial begin : byte_sender
        int     next_idx;
        int     pct;
        t_phase ph;
        next_idx = 0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        wait (run_on);
        forever begin
            @(negedge i_clk);
            // move on once the offered byte has been transferred
            if (!rx_if.valid || accepted_cnt == next_idx) begin
                ph  = phase_of(next_idx);
                pct = (ph == PH_TX_IDLE) ? 65 : (ph == PH_BOTH) ? 16 : 0;
                if (next_idx < stim_byte.size() && $urandom_range(99) >= pct) begin
                    rx_if.valid   <= 1'b1;
                    rx_if.rx_byte <= stim_byte[next_idx];
                    next_idx++;
                end else begin
                    rx_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // status receiver, with one long hold-off to back up the input
    // ------------------------------------------------------------------
    initial begin : status_receiver
        int     hold_left;
        bit     held;
        int     pct;
        t_phase ph;
        hold_left = 0;
        held      = 1'b0;
        res_if.ready <= 1'b0;
        wait (run_on);
        forever begin
            @(negedge i_clk);
            ph = phase_of(got_cnt);
            if (ph == PH_PRESSURE && !held) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            pct = (ph == PH_RX_STALL) ? 65 : (ph == PH_BOTH) ? 16 : 0;
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : main_sequence
        i_rst_n      = 1'b0;
        run_on       = 1'b0;
        accepted_cnt = 0;
        got_cnt      = 0;
        err_count    = 0;
        close_frame();
        dec_auto = 1'b0;
        dec_duty = '0;

        // directed table
        push_byte(8'hff, 1'b1, mk_res(1'b0, 7'd0, 1'b0, 1'b0, KIND_NONE));
        add_text("#manual$", -1, 1'b1, mk_res(1'b0, 7'd0, 1'b1, 1'b0, KIND_MANUAL));
        add_text("#PWM99$", -1, 1'b1, mk_res(1'b0, 7'd99, 1'b1, 1'b0, KIND_DUTY));
        add_text("#auto$", -1, 1'b1, mk_res(1'b1, 7'd99, 1'b1, 1'b0, KIND_AUTO));
        add_text("#PWM$", -1, 1'b1, mk_res(1'b1, 7'd99, 1'b1, 1'b0, KIND_NONE));
        n_directed = stim_byte.size();

        build_random(FRAMED_ITEMS);

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        run_on  = 1'b1;

        while (accepted_cnt < stim_byte.size() || pending_status_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // run limit
    initial begin : run_limit
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
